FILE: rtl/cdsw_pkg.sv
`timescale 1ns / 1ps

package cdsw_pkg;

    localparam int unsigned MinW       = 10;
    localparam int unsigned SecW       = 6;
    localparam int unsigned TenthsW    = 4;
    localparam int unsigned MsW        = 10;
    localparam int unsigned SubW       = 7;
    localparam int unsigned SwMinW     = 7;

    localparam logic [MinW-1:0]    MAX_MINUTES     = 10'd999;
    localparam logic [MinW-1:0]    DEFAULT_MINUTES = 10'd26;
    localparam logic [MsW-1:0]     MS_LAST         = 10'd999;
    localparam logic [SecW-1:0]    SEC_LAST        = 6'd59;
    localparam logic [SubW-1:0]    SUB_LAST        = 7'd99;
    localparam logic [TenthsW-1:0] TENTHS_LAST     = 4'd9;
    localparam logic [SwMinW-1:0]  SW_MIN_LAST     = 7'd99;

    typedef enum logic [2:0] {
        REQ_TICK        = 3'd0,
        REQ_FOCUS_START = 3'd1,
        REQ_FOCUS_STOP  = 3'd2,
        REQ_SW_START    = 3'd3,
        REQ_SW_PAUSE    = 3'd4,
        REQ_SW_RESET    = 3'd5,
        REQ_SW_EXIT     = 3'd6
    } req_type_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FOCUS = 2'd1,
        MODE_SW    = 2'd2
    } mode_t;

endpackage

FILE: rtl/cdsw_ifs.sv
`timescale 1ns / 1ps

interface cdsw_req_if import cdsw_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [2:0]      req_type;
    logic [MinW-1:0] minutes;

    modport source (output valid, output req_type, output minutes, input ready);
    modport sink   (input valid, input req_type, input minutes, output ready);
endinterface

interface cdsw_rsp_if import cdsw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [MinW-1:0]    disp_minutes;
    logic [SecW-1:0]    disp_seconds;
    logic [TenthsW-1:0] disp_tenths;
    logic               sw_running;
    logic               focus_done;

    modport source (
        output valid, output mode, output disp_minutes, output disp_seconds,
        output disp_tenths, output sw_running, output focus_done, input ready
    );
    modport sink (
        input valid, input mode, input disp_minutes, input disp_seconds,
        input disp_tenths, input sw_running, input focus_done, output ready
    );
endinterface

FILE: rtl/countdown_and_stopwatch_timer_top.sv
`timescale 1ns / 1ps
// channel   | dir | handshake    | payload
// ----------+-----+--------------+------------------------------------------------
// req       | in  | valid/ready  | req_type[2:0], minutes[9:0]
// rsp       | out | valid/ready  | mode, disp_minutes, disp_seconds, disp_tenths,
//           |     |              | sw_running, focus_done
// cfg       | in  | cfg_wr_en    | cfg_wr_data[9:0] (default focus minutes)
//
// one req beat in, one rsp beat out; a beat can enter every cycle while rsp is not stalled
// each beat passes the input register, then the state update into the result register
// both registers advance together when the result register is empty or being taken,
// so a stalled rsp holds its beat and req backs up one stage at a time
// rst_n clears all control and timer state asynchronously; default minutes reset to 26

module countdown_and_stopwatch_timer_top
    import cdsw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    cdsw_req_if.sink        req,
    cdsw_rsp_if.source      rsp,
    input  logic            cfg_wr_en,
    input  logic [MinW-1:0] cfg_wr_data
);

    // input stage
    logic            in_valid_reg;
    logic [2:0]      in_type_reg;
    logic [MinW-1:0] in_minutes_reg;

    // result stage
    logic               out_valid_reg;
    mode_t              out_mode_reg;
    logic [MinW-1:0]    out_minutes_reg;
    logic [SecW-1:0]    out_seconds_reg;
    logic [TenthsW-1:0] out_tenths_reg;
    logic               out_running_reg;
    logic               out_done_reg;

    // configuration
    logic [MinW-1:0] default_min_reg;

    // countdown keeps the remaining time as minutes and seconds, no divide needed
    logic            focus_on_reg,  focus_on_next;
    logic [MinW-1:0] focus_min_reg, focus_min_next;
    logic [SecW-1:0] focus_sec_reg, focus_sec_next;
    logic [MsW-1:0]  focus_ms_reg,  focus_ms_next;

    // stopwatch keeps ms split into tenths and the ms inside a tenth
    logic               sw_shown_reg,    sw_shown_next;
    logic               sw_counting_reg, sw_counting_next;
    logic [SubW-1:0]    sw_sub_reg,      sw_sub_next;
    logic [TenthsW-1:0] sw_tenths_reg,   sw_tenths_next;
    logic [SecW-1:0]    sw_sec_reg,      sw_sec_next;
    logic [SwMinW-1:0]  sw_min_reg,      sw_min_next;

    logic            done_next;
    logic            advance;
    logic [MinW-1:0] start_min;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    // zero asks for the default, large values saturate
    always_comb
    begin
        start_min = (in_minutes_reg == '0) ? default_min_reg : in_minutes_reg;
        if (start_min > MAX_MINUTES)
        begin
            start_min = MAX_MINUTES;
        end
    end

    always_comb
    begin
        focus_on_next    = focus_on_reg;
        focus_min_next   = focus_min_reg;
        focus_sec_next   = focus_sec_reg;
        focus_ms_next    = focus_ms_reg;
        sw_shown_next    = sw_shown_reg;
        sw_counting_next = sw_counting_reg;
        sw_sub_next      = sw_sub_reg;
        sw_tenths_next   = sw_tenths_reg;
        sw_sec_next      = sw_sec_reg;
        sw_min_next      = sw_min_reg;
        done_next        = 1'b0;

        unique case (req_type_t'(in_type_reg))
            REQ_TICK:
            begin
                if (focus_on_reg)
                begin
                    if (focus_ms_reg == MS_LAST)
                    begin
                        focus_ms_next = '0;
                        // one more whole second elapsed
                        if (focus_sec_reg == '0)
                        begin
                            focus_sec_next = SEC_LAST;
                            focus_min_next = focus_min_reg - 1'b1;
                        end
                        else
                        begin
                            focus_sec_next = focus_sec_reg - 1'b1;
                        end
                        // expiry when the last second runs out
                        if ((focus_min_reg == '0) && (focus_sec_reg == SecW'(1)))
                        begin
                            focus_on_next = 1'b0;
                            done_next     = 1'b1;
                        end
                    end
                    else
                    begin
                        focus_ms_next = focus_ms_reg + 1'b1;
                    end
                end
                if (sw_counting_reg)
                begin
                    if (sw_sub_reg == SUB_LAST)
                    begin
                        sw_sub_next = '0;
                        if (sw_tenths_reg == TENTHS_LAST)
                        begin
                            sw_tenths_next = '0;
                            if (sw_sec_reg == SEC_LAST)
                            begin
                                sw_sec_next = '0;
                                sw_min_next = (sw_min_reg == SW_MIN_LAST) ? '0
                                                                          : sw_min_reg + 1'b1;
                            end
                            else
                            begin
                                sw_sec_next = sw_sec_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            sw_tenths_next = sw_tenths_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sw_sub_next = sw_sub_reg + 1'b1;
                    end
                end
            end
            REQ_FOCUS_START:
            begin
                focus_on_next  = 1'b1;
                focus_min_next = start_min;
                focus_sec_next = '0;
                focus_ms_next  = '0;
                sw_shown_next  = 1'b0;   // stopwatch keeps running hidden
            end
            REQ_FOCUS_STOP:
            begin
                focus_on_next = 1'b0;
            end
            REQ_SW_START:
            begin
                sw_counting_next = 1'b1;
                sw_shown_next    = 1'b1;
                focus_on_next    = 1'b0;
            end
            REQ_SW_PAUSE:
            begin
                sw_counting_next = 1'b0;
            end
            REQ_SW_RESET:
            begin
                sw_sub_next    = '0;
                sw_tenths_next = '0;
                sw_sec_next    = '0;
                sw_min_next    = '0;
            end
            REQ_SW_EXIT:
            begin
                sw_shown_next    = 1'b0;
                sw_counting_next = 1'b0;
                sw_sub_next      = '0;
                sw_tenths_next   = '0;
                sw_sec_next      = '0;
                sw_min_next      = '0;
            end
            default:
            begin
                // unused code: display only
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg    <= req.req_type;
            in_minutes_reg <= req.minutes;
        end
    end

    // configuration register, clamped to 1..MAX_MINUTES on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_min_reg <= DEFAULT_MINUTES;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
            begin
                default_min_reg <= MinW'(1);
            end
            else if (cfg_wr_data > MAX_MINUTES)
            begin
                default_min_reg <= MAX_MINUTES;
            end
            else
            begin
                default_min_reg <= cfg_wr_data;
            end
        end
    end

    // timer state, updated once per beat leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_on_reg    <= 1'b0;
            focus_min_reg   <= DEFAULT_MINUTES;
            focus_sec_reg   <= '0;
            focus_ms_reg    <= '0;
            sw_shown_reg    <= 1'b0;
            sw_counting_reg <= 1'b0;
            sw_sub_reg      <= '0;
            sw_tenths_reg   <= '0;
            sw_sec_reg      <= '0;
            sw_min_reg      <= '0;
        end
        else if (advance)
        begin
            focus_on_reg    <= focus_on_next;
            focus_min_reg   <= focus_min_next;
            focus_sec_reg   <= focus_sec_next;
            focus_ms_reg    <= focus_ms_next;
            sw_shown_reg    <= sw_shown_next;
            sw_counting_reg <= sw_counting_next;
            sw_sub_reg      <= sw_sub_next;
            sw_tenths_reg   <= sw_tenths_next;
            sw_sec_reg      <= sw_sec_next;
            sw_min_reg      <= sw_min_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // display follows the state after the beat; countdown wins over stopwatch
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_running_reg <= sw_counting_next;
            out_done_reg    <= done_next;
            if (focus_on_next)
            begin
                out_mode_reg    <= MODE_FOCUS;
                out_minutes_reg <= focus_min_next;
                out_seconds_reg <= focus_sec_next;
                out_tenths_reg  <= '0;
            end
            else if (sw_shown_next)
            begin
                out_mode_reg    <= MODE_SW;
                out_minutes_reg <= MinW'(sw_min_next);
                out_seconds_reg <= sw_sec_next;
                out_tenths_reg  <= sw_tenths_next;
            end
            else
            begin
                out_mode_reg    <= MODE_IDLE;
                out_minutes_reg <= '0;
                out_seconds_reg <= '0;
                out_tenths_reg  <= '0;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.mode         = out_mode_reg;
    assign rsp.disp_minutes = out_minutes_reg;
    assign rsp.disp_seconds = out_seconds_reg;
    assign rsp.disp_tenths  = out_tenths_reg;
    assign rsp.sw_running   = out_running_reg;
    assign rsp.focus_done   = out_done_reg;

endmodule

FILE: rtl/cdsw_checker.sv
`timescale 1ns / 1ps

module cdsw_checker
    import cdsw_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [1:0]         rsp_mode,
    input logic [MinW-1:0]    rsp_minutes,
    input logic [SecW-1:0]    rsp_seconds,
    input logic [TenthsW-1:0] rsp_tenths,
    input logic               rsp_done
);

    // a stalled beat stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp beat dropped while stalled");

    // expiry leaves the countdown display
    a_done_mode: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_done |-> rsp_mode != MODE_FOCUS)
        else $error("countdown still shown on expiry");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_mode == MODE_IDLE |->
            rsp_minutes == '0 && rsp_seconds == '0 && rsp_tenths == '0)
        else $error("idle display not blank");

    a_focus_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_mode == MODE_FOCUS |->
            rsp_tenths == '0 && rsp_seconds <= SEC_LAST && rsp_minutes <= MAX_MINUTES)
        else $error("countdown display out of range");

    a_sw_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_mode == MODE_SW |->
            rsp_minutes <= MinW'(SW_MIN_LAST) && rsp_seconds <= SEC_LAST
            && rsp_tenths <= TENTHS_LAST)
        else $error("stopwatch display out of range");

endmodule

bind countdown_and_stopwatch_timer_top cdsw_checker u_cdsw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_mode    (rsp.mode),
    .rsp_minutes (rsp.disp_minutes),
    .rsp_seconds (rsp.disp_seconds),
    .rsp_tenths  (rsp.disp_tenths),
    .rsp_done    (rsp.focus_done)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import cdsw_pkg::*;

    // code 7 is not a request; the block must answer it with the current display
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    localparam int     ClkHalfNs  = 4;
    localparam int     ResetCyc   = 7;
    localparam int     PhaseItems = 120;
    localparam int     PhaseCount = 6;
    localparam int     PrintCap   = 50;
    // worst case is far below this: ~1.9k beats, each held only by bounded gaps and stalls
    localparam longint TimeoutNs  = 64'd10_000_000;

    // one display beat as the block reports it
    typedef struct packed {
        mode_t              mode;
        logic [MinW-1:0]    mins;
        logic [SecW-1:0]    secs;
        logic [TenthsW-1:0] tenths;
        logic               running;
        logic               done;
    } display_t;

    // one row of the directed plan; want is only used when typed is set
    typedef struct packed {
        logic [2:0]      kind;
        logic [MinW-1:0] mn;
        logic            typed;
        display_t        want;
    } plan_row_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [MinW-1:0] cfg_wr_data;

    cdsw_req_if req_ch ();
    cdsw_rsp_if rsp_ch ();

    countdown_and_stopwatch_timer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // predictor state: countdown, stopwatch and the default length
    // ------------------------------------------------------------------
    logic [MinW-1:0]   dflt_min   = DEFAULT_MINUTES;
    logic              cd_on      = 1'b0;
    logic              cd_over    = 1'b0;
    logic [15:0]       cd_total   = 16'd1560;
    logic [MsW-1:0]    cd_ms      = '0;
    logic [15:0]       cd_elapsed = '0;
    logic              sw_vis     = 1'b0;
    logic              sw_run     = 1'b0;
    logic [MsW-1:0]    sw_msec    = '0;
    logic [SecW-1:0]   sw_secs    = '0;
    logic [SwMinW-1:0] sw_mins    = '0;

    display_t due_displays [$];
    int       mismatches = 0;
    int       idle_level = 2;   // 0 no gaps, 1 light, 2 full mix of short and long

    // countdown lengths are kept within 1 .. MAX_MINUTES
    function automatic logic [MinW-1:0] clamp_len(input logic [MinW-1:0] v);
        if (v == '0)
            return 10'd1;
        if (v > MAX_MINUTES)
            return MAX_MINUTES;
        return v;
    endfunction

    // applies one request beat to the predictor and returns the display after it
    function automatic display_t advance_timer(input logic [2:0] kind,
                                               input logic [MinW-1:0] mn);
        display_t        d;
        logic [MinW-1:0] len;
        logic [15:0]     left;
        d      = '0;
        d.mode = MODE_IDLE;
        case (kind)
            REQ_TICK:
            begin
                // countdown only moves while active and not yet expired
                if (cd_on && !cd_over)
                begin
                    if (cd_ms == MS_LAST)
                    begin
                        cd_ms = '0;
                        if (cd_elapsed != 16'hFFFF)
                            cd_elapsed++;
                    end
                    else
                        cd_ms++;
                    if (cd_elapsed >= cd_total)
                    begin
                        cd_over = 1'b1;
                        cd_on   = 1'b0;
                        d.done  = 1'b1;
                    end
                end
                // stopwatch runs in the background, minutes wrap at 100
                if (sw_run)
                begin
                    if (sw_msec == MS_LAST)
                    begin
                        sw_msec = '0;
                        if (sw_secs == SEC_LAST)
                        begin
                            sw_secs = '0;
                            sw_mins = (sw_mins == SW_MIN_LAST) ? '0 : sw_mins + 1'b1;
                        end
                        else
                            sw_secs++;
                    end
                    else
                        sw_msec++;
                end
            end
            REQ_FOCUS_START:
            begin
                len        = clamp_len((mn == '0) ? dflt_min : mn);
                cd_total   = 16'(len) * 16'd60;
                cd_ms      = '0;
                cd_elapsed = '0;
                cd_on      = 1'b1;
                cd_over    = 1'b0;
                sw_vis     = 1'b0;
            end
            REQ_FOCUS_STOP:
            begin
                cd_on   = 1'b0;
                cd_over = 1'b0;
            end
            REQ_SW_START:
            begin
                sw_run = 1'b1;
                sw_vis = 1'b1;
                cd_on  = 1'b0;
            end
            REQ_SW_PAUSE:
                sw_run = 1'b0;
            REQ_SW_RESET:
            begin
                sw_msec = '0;
                sw_secs = '0;
                sw_mins = '0;
            end
            REQ_SW_EXIT:
            begin
                sw_vis  = 1'b0;
                sw_run  = 1'b0;
                sw_msec = '0;
                sw_secs = '0;
                sw_mins = '0;
            end
            default: ;
        endcase

        // countdown has display priority over the stopwatch
        if (cd_on)
        begin
            left   = (cd_elapsed < cd_total) ? cd_total - cd_elapsed : 16'd0;
            d.mode = MODE_FOCUS;
            d.mins = MinW'(left / 16'd60);
            d.secs = SecW'(left % 16'd60);
        end
        else if (sw_vis)
        begin
            d.mode   = MODE_SW;
            d.mins   = MinW'(sw_mins);
            d.secs   = sw_secs;
            d.tenths = TenthsW'(sw_msec / 10'd100);
        end
        d.running = sw_run;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and the timeout guard
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #(ClkHalfNs) clk = ~clk;

    initial
    begin
        #(TimeoutNs);
        $display("Simulation FAILED");
        $finish;
    end

    // gap lengths, mostly short with a rare long one, scaled by idle_level
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_level == 0)
            return 0;
        if (idle_level == 1)
            return (r < 95) ? 0 : $urandom_range(1, 2);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // minutes for a start beat: default, short, extreme or anything
    function automatic logic [MinW-1:0] draw_minutes();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return '0;
        if (r < 6)
            return MinW'($urandom_range(1, 5));
        if (r < 8)
            return MinW'($urandom);
        if (r < 9)
            return MinW'($urandom_range(999, 1023));
        return MinW'($urandom_range(1, 999));
    endfunction

    // ------------------------------------------------------------------
    // response side: random stalls on ready, checker on each taken beat
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    function automatic void report_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= PrintCap)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        display_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (due_displays.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PrintCap)
                    $display("%0t ns: display beat with nothing expected, got mode %0d",
                             $time, rsp_ch.mode);
            end
            else
            begin
                want = due_displays.pop_front();
                report_field("mode", 16'(want.mode), 16'(rsp_ch.mode));
                report_field("disp_minutes", 16'(want.mins), 16'(rsp_ch.disp_minutes));
                report_field("disp_seconds", 16'(want.secs), 16'(rsp_ch.disp_seconds));
                report_field("disp_tenths", 16'(want.tenths), 16'(rsp_ch.disp_tenths));
                report_field("sw_running", 16'(want.running), 16'(rsp_ch.sw_running));
                report_field("focus_done", 16'(want.done), 16'(rsp_ch.focus_done));
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // drives one request beat from a falling edge, waits for it to be taken,
    // then queues the display it must produce; valid stays high between
    // back-to-back beats and drops only for a gap
    task automatic send_beat(input logic [2:0] kind, input logic [MinW-1:0] mn,
                             input logic typed, input display_t want);
        int       gap;
        display_t next;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.minutes  <= mn;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        next = advance_timer(kind, mn);
        due_displays.push_back(typed ? want : next);
        @(negedge clk);
    endtask

    // stop sending and wait until every queued display has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (due_displays.size() != 0);
    endtask

    // default length write; only called with the block drained
    task automatic write_default(input logic [MinW-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        dflt_min = clamp_len(v);
    endtask

    // random mix: runs of ticks with commands in between, minutes always random
    // so that the ignored field still toggles
    task automatic random_phase(input int n_items);
        int         sent;
        int         pick;
        int         burst;
        logic [2:0] kind;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                    : $urandom_range(1, 12);
                repeat (burst) send_beat(REQ_TICK, MinW'($urandom), 1'b0, '0);
                sent += burst;
            end
            else
            begin
                if (pick < 68)
                    kind = REQ_FOCUS_START;
                else if (pick < 74)
                    kind = REQ_FOCUS_STOP;
                else if (pick < 83)
                    kind = REQ_SW_START;
                else if (pick < 89)
                    kind = REQ_SW_PAUSE;
                else if (pick < 93)
                    kind = REQ_SW_RESET;
                else if (pick < 97)
                    kind = REQ_SW_EXIT;
                else
                    kind = REQ_UNUSED;
                send_beat(kind, (kind == REQ_FOCUS_START) ? draw_minutes() : MinW'($urandom),
                          1'b0, '0);
                sent++;
            end
        end
    endtask

    // directed plan: reset display, unused code, default and clamped lengths,
    // every command, stopwatch running behind a countdown, alternating minute bits
    plan_row_t plan [24] = '{
        '{REQ_TICK,        10'd0,    1'b1, '{MODE_IDLE,  10'd0,   6'd0, 4'd0, 1'b0, 1'b0}},
        '{REQ_UNUSED,      10'd1023, 1'b1, '{MODE_IDLE,  10'd0,   6'd0, 4'd0, 1'b0, 1'b0}},
        '{REQ_FOCUS_START, 10'd0,    1'b1, '{MODE_FOCUS, 10'd26,  6'd0, 4'd0, 1'b0, 1'b0}},
        '{REQ_TICK,        10'd0,    1'b0, '0},
        '{REQ_FOCUS_START, 10'd1023, 1'b1, '{MODE_FOCUS, 10'd999, 6'd0, 4'd0, 1'b0, 1'b0}},
        '{REQ_FOCUS_START, 10'd1,    1'b1, '{MODE_FOCUS, 10'd1,   6'd0, 4'd0, 1'b0, 1'b0}},
        '{REQ_TICK,        10'd1023, 1'b0, '0},
        '{REQ_FOCUS_STOP,  10'd1023, 1'b1, '{MODE_IDLE,  10'd0,   6'd0, 4'd0, 1'b0, 1'b0}},
        '{REQ_FOCUS_STOP,  10'd0,    1'b1, '{MODE_IDLE,  10'd0,   6'd0, 4'd0, 1'b0, 1'b0}},
        '{REQ_SW_START,    10'd0,    1'b1, '{MODE_SW,    10'd0,   6'd0, 4'd0, 1'b1, 1'b0}},
        '{REQ_TICK,        10'd0,    1'b0, '0},
        '{REQ_SW_PAUSE,    10'd1023, 1'b0, '0},
        '{REQ_TICK,        10'd512,  1'b0, '0},
        '{REQ_SW_RESET,    10'd0,    1'b1, '{MODE_SW,    10'd0,   6'd0, 4'd0, 1'b0, 1'b0}},
        '{REQ_SW_START,    10'd1023, 1'b1, '{MODE_SW,    10'd0,   6'd0, 4'd0, 1'b1, 1'b0}},
        '{REQ_FOCUS_START, 10'd999,  1'b1, '{MODE_FOCUS, 10'd999, 6'd0, 4'd0, 1'b1, 1'b0}},
        '{REQ_TICK,        10'd0,    1'b0, '0},
        '{REQ_SW_START,    10'd0,    1'b0, '0},
        '{REQ_FOCUS_START, 10'd682,  1'b1, '{MODE_FOCUS, 10'd682, 6'd0, 4'd0, 1'b1, 1'b0}},
        '{REQ_SW_EXIT,     10'd1023, 1'b0, '0},
        '{REQ_FOCUS_START, 10'd341,  1'b1, '{MODE_FOCUS, 10'd341, 6'd0, 4'd0, 1'b0, 1'b0}},
        '{REQ_FOCUS_STOP,  10'd0,    1'b1, '{MODE_IDLE,  10'd0,   6'd0, 4'd0, 1'b0, 1'b0}},
        '{REQ_SW_RESET,    10'd1023, 1'b1, '{MODE_IDLE,  10'd0,   6'd0, 4'd0, 1'b0, 1'b0}},
        '{REQ_SW_PAUSE,    10'd0,    1'b1, '{MODE_IDLE,  10'd0,   6'd0, 4'd0, 1'b0, 1'b0}}
    };

    // default lengths per random phase: both clamps, both ends, two random values
    logic [MinW-1:0] phase_default [PhaseCount];

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_TICK;
        req_ch.minutes  = '0;
        phase_default   = '{10'd1023, 10'd1, 10'd999, MinW'($urandom), 10'd0,
                            MinW'($urandom_range(2, 998))};
        repeat (ResetCyc) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed rows, default length still at its reset value
        idle_level = 2;
        foreach (plan[i])
            send_beat(plan[i].kind, plan[i].mn, plan[i].typed, plan[i].want);
        drain();

        // a written zero default means one minute; the countdown and the
        // stopwatch behind it both run past a whole second
        write_default(10'd0);
        idle_level = 1;
        send_beat(REQ_SW_START, 10'd0, 1'b0, '0);
        send_beat(REQ_FOCUS_START, 10'd0, 1'b0, '0);
        repeat (1100) send_beat(REQ_TICK, MinW'($urandom), 1'b0, '0);
        drain();

        // random phases, each behind a drained default write
        for (int p = 0; p < PhaseCount; p++)
        begin
            write_default(phase_default[p]);
            idle_level = (p % 3 == 1) ? 0 : 2 - (p % 3) / 2;
            random_phase(PhaseItems);
            drain();
        end

        // let the two-stage pipeline settle before the verdict
        repeat (4) @(negedge clk);
        if (mismatches == 0 && due_displays.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cdsw_pkg.sv
rtl/cdsw_ifs.sv
rtl/countdown_and_stopwatch_timer_top.sv
rtl/cdsw_checker.sv
dv/tb_top.sv
